/* rtl/heap_sort_engine_unit_defines.svh */
// Assertion macros shared by the heap sort engine RTL.
`ifndef HEAP_SORT_ENGINE_UNIT_DEFINES_SVH
`define HEAP_SORT_ENGINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge of clk outside reset.
`define HSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge of clk, reset included.
`define HSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSE_ASSERT(lbl, prop, msg)
`define HSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/hse_pkg.sv */
// Package of types and constants for the heap sort engine.
package hse_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     dropped;
    } result_t;

endpackage

/* rtl/heap_sort_engine_unit.sv */
// Heap sort engine: collects signed values into a local store and emits them in ascending order.
//
// Items are taken one per cycle into a store of MAX_ITEMS entries; the item with last set closes
// the set and the block then stalls its input until the last result of the set has been loaded
// into the result register. Sorting runs on one store with a single write port and one read port
// under a small sequencer: each sift level reads the left child, reads the right child if there
// is one, compares and writes back, a sift that ends on a leaf writes the entry back from S_SL,
// each parent of the build phase is first fetched through S_BSTART and S_LDCUR, each heap
// extraction swaps the root through S_EX0, S_EX1 and S_EX2, and each result is read out through
// S_ERD and S_EOUT and loaded once the output is free. The store's one read port sets the pace
// of the sort. Values arriving when the store is full are discarded and every result of that set
// carries the dropped flag. The result register decouples the output, so the last result of a
// set may still wait while the first item of the next set is accepted.
module heap_sort_engine_unit #(
    parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  hse_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output hse_pkg::result_t result
);

`include "heap_sort_engine_unit_defines.svh"

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DW     = hse_pkg::DATA_W;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BSTART = 4'd1;
    localparam logic [3:0] S_LDCUR  = 4'd2;
    localparam logic [3:0] S_SL     = 4'd3;
    localparam logic [3:0] S_SR     = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_DEC    = 4'd6;
    localparam logic [3:0] S_EX0    = 4'd7;
    localparam logic [3:0] S_EX1    = 4'd8;
    localparam logic [3:0] S_EX2    = 4'd9;
    localparam logic [3:0] S_ERD    = 4'd10;
    localparam logic [3:0] S_EOUT   = 4'd11;

    localparam logic PH_BUILD   = 1'b0;
    localparam logic PH_EXTRACT = 1'b1;

    // store, single write port and one registered read port
    logic signed [DW-1:0] mem [MAX_ITEMS];
    logic signed [DW-1:0] mem_q_reg;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic signed [DW-1:0] wr_data;
    logic [ADDR_W-1:0]    rd_addr;

    // control and datapath registers
    logic [3:0]           state_reg,   state_next;
    logic                 phase_reg,   phase_next;
    logic [CNT_W-1:0]     fill_reg,    fill_next;
    logic                 ovf_reg,     ovf_next;
    logic [CNT_W-1:0]     len_reg,     len_next;
    logic [CNT_W-1:0]     par_reg,     par_next;
    logic [ADDR_W-1:0]    pos_reg,     pos_next;
    logic [ADDR_W-1:0]    cidx_reg,    cidx_next;
    logic [ADDR_W-1:0]    k_reg,       k_next;
    logic signed [DW-1:0] cur_reg,     cur_next;
    logic signed [DW-1:0] child_reg,   child_next;
    logic                 rvalid_reg,  rvalid_next;
    hse_pkg::result_t     result_reg,  result_next;

    logic [CNT_W-1:0]     lft;
    logic [CNT_W-1:0]     rgt;
    logic                 item_acc;
    logic                 out_free;
    logic                 emit_last;
    logic                 sift_done;

    assign lft       = {pos_reg, 1'b1};
    assign rgt       = lft + CNT_W'(1);
    assign item_acc  = item_valid && !item_stall;
    assign out_free  = !rvalid_reg || !result_stall;
    assign emit_last = (CNT_W'(k_reg) + CNT_W'(1)) == fill_reg;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = rvalid_reg;
    assign result       = result_reg;

    // store access
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        len_next    = len_reg;
        par_next    = par_reg;
        pos_next    = pos_reg;
        cidx_next   = cidx_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        child_next  = child_reg;
        rvalid_next = rvalid_reg;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = cur_reg;
        rd_addr     = pos_reg;
        sift_done   = 1'b0;

        // drop the result once it has been taken
        if (rvalid_reg && !result_stall)
        begin
            rvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    if (fill_reg < MAX_CNT)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = fill_reg[ADDR_W-1:0];
                        wr_data   = item.value;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        len_next   = fill_next;
                        par_next   = fill_next >> 1;
                        k_next     = '0;
                        state_next = S_BSTART;
                    end
                end
            end
            S_BSTART:
            begin
                // sift the next parent, or move on to extraction
                if (par_reg != '0)
                begin
                    pos_next   = ADDR_W'(par_reg - CNT_W'(1));
                    rd_addr    = ADDR_W'(par_reg - CNT_W'(1));
                    phase_next = PH_BUILD;
                    state_next = S_LDCUR;
                end
                else
                begin
                    state_next = S_EX0;
                end
            end
            S_LDCUR:
            begin
                cur_next   = mem_q_reg;
                state_next = S_SL;
            end
            S_SL:
            begin
                if (lft < len_reg)
                begin
                    rd_addr    = lft[ADDR_W-1:0];
                    state_next = S_SR;
                end
                else
                begin
                    wr_en     = 1'b1;
                    sift_done = 1'b1;
                end
            end
            S_SR:
            begin
                child_next = mem_q_reg;
                cidx_next  = lft[ADDR_W-1:0];
                if (rgt < len_reg)
                begin
                    rd_addr    = rgt[ADDR_W-1:0];
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_CMP:
            begin
                // keep the larger child
                if (mem_q_reg > child_reg)
                begin
                    child_next = mem_q_reg;
                    cidx_next  = rgt[ADDR_W-1:0];
                end
                state_next = S_DEC;
            end
            S_DEC:
            begin
                wr_en = 1'b1;
                if (child_reg > cur_reg)
                begin
                    wr_data    = child_reg;
                    pos_next   = cidx_reg;
                    state_next = S_SL;
                end
                else
                begin
                    sift_done = 1'b1;
                end
            end
            S_EX0:
            begin
                if (len_reg > CNT_W'(1))
                begin
                    rd_addr    = '0;
                    phase_next = PH_EXTRACT;
                    state_next = S_EX1;
                end
                else
                begin
                    state_next = S_ERD;
                end
            end
            S_EX1:
            begin
                child_next = mem_q_reg;
                rd_addr    = ADDR_W'(len_reg - CNT_W'(1));
                state_next = S_EX2;
            end
            S_EX2:
            begin
                // park the root at the end, sift the displaced entry from the top
                wr_en      = 1'b1;
                wr_addr    = ADDR_W'(len_reg - CNT_W'(1));
                wr_data    = child_reg;
                cur_next   = mem_q_reg;
                len_next   = len_reg - CNT_W'(1);
                pos_next   = '0;
                state_next = S_SL;
            end
            S_ERD:
            begin
                rd_addr    = k_reg;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                rd_addr = k_reg;
                if (out_free)
                begin
                    rvalid_next              = 1'b1;
                    result_next.sorted_value = mem_q_reg;
                    result_next.final_res    = emit_last;
                    result_next.dropped      = ovf_reg;
                    if (emit_last)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // return from a sift to the phase that called it
        if (sift_done)
        begin
            if (phase_reg == PH_BUILD)
            begin
                par_next   = par_reg - CNT_W'(1);
                state_next = S_BSTART;
            end
            else
            begin
                state_next = S_EX0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_BUILD;
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            ovf_reg    <= ovf_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        par_reg    <= par_next;
        pos_reg    <= pos_next;
        cidx_reg   <= cidx_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        child_reg  <= child_next;
        result_reg <= result_next;
    end

    `HSE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !result_valid && !item_stall, "busy after reset")
    `HSE_ASSERT(a_fill_bound, fill_reg <= MAX_CNT, "fill count beyond capacity")
    `HSE_ASSERT(a_last_starts_sort, item_acc && item.last |=> state_reg == S_BSTART, "no sort")
    `HSE_ASSERT(a_hole_in_heap, state_reg == S_SL |-> CNT_W'(pos_reg) < len_reg, "hole outside heap")
    `HSE_ASSERT(a_len_in_fill, state_reg != S_IDLE |-> len_reg <= fill_reg, "heap beyond set")
    `HSE_ASSERT(a_emit_in_set, state_reg == S_EOUT |-> CNT_W'(k_reg) < fill_reg, "emit beyond set")

endmodule
